FILE: rtl/sri_pkg.sv
// ----------------------------------------------------------------------------
// sri_pkg
// Shared constants, types and a helper function of the servo ramp interpolator.
// ----------------------------------------------------------------------------
package sri_pkg;

    localparam int FIELD_SERVOS      = 4;
    localparam int SERVO_COUNT_DEF   = 4;

    localparam int DEG_W     = 8;
    localparam int ANGLE_W   = 16;
    localparam int STEP_W    = 18;
    localparam int TICKS_W   = 13;
    localparam int DUR_W     = 16;
    localparam int PULSE_W   = 12;
    localparam int TRIM_W    = 8;
    localparam int SPAN_W    = PULSE_W + 1;
    localparam int CLAMP_W   = ANGLE_W + 3;
    localparam int PROD_W    = ANGLE_W + 1 + SPAN_W;
    localparam int SUM_W     = 22;
    localparam int BASE_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam int DIVIDEND_W = 19;
    localparam int DIVISOR_W  = DUR_W;
    localparam int QUOT_W     = 17;

    localparam int MAX_DEG   = 180;
    localparam int RESET_DEG = 80;
    localparam int TICK_MS   = 10;
    localparam int FULL_Q    = MAX_DEG * 256;

    // pulse = floor(num / 46080) done as (num >> 10) / 45
    localparam int DIV_SHIFT   = 10;
    localparam int SCALE_MUL   = FULL_Q / 1024;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 19;
    localparam int RECIP_45    = ((1 << RECIP_SHIFT) + SCALE_MUL - 1) / SCALE_MUL;
    localparam int SCALE_W     = BASE_W + RECIP_W;

    // ceil(d / 10) as ((d + 9) * 52429) >> 19
    localparam int TICK_RECIP       = 52429;
    localparam int TICK_RECIP_SHIFT = 19;
    localparam int TICK_RECIP_W     = 16;
    localparam int TICK_PROD_W      = DUR_W + 1 + TICK_RECIP_W;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = PULSE_W'(544);
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = PULSE_W'(2400);

    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE = 3'd0,
        REG_MAX_PULSE = 3'd1,
        REG_REVERSE   = 3'd2,
        REG_TRIM_0    = 3'd3,
        REG_TRIM_1    = 3'd4,
        REG_TRIM_2    = 3'd5,
        REG_TRIM_3    = 3'd6
    } sri_reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_TRIM,
        ST_SPAN,
        ST_SUM,
        ST_SCALE,
        ST_DELIVER
    } sri_state_t;

    typedef struct packed {
        logic move_en;
        logic snap;
        logic tick_en;
        logic last_tick;
        logic trim_en;
        logic span_en;
        logic sum_en;
        logic scale_en;
    } sri_lane_ctrl_t;

    // saturate a signed 19-bit value with 8 fraction bits into 0..180 degrees in Q8.8
    function automatic logic [ANGLE_W-1:0] clamp_q(input logic signed [CLAMP_W-1:0] v);
        logic [ANGLE_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed(CLAMP_W'(FULL_Q)))
        begin
            r = ANGLE_W'(FULL_Q);
        end
        else
        begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/sri_channels.sv
// ----------------------------------------------------------------------------
// sri channels
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
interface sri_req_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [sri_pkg::DEG_W-1:0]       target_0;
    logic [sri_pkg::DEG_W-1:0]       target_1;
    logic [sri_pkg::DEG_W-1:0]       target_2;
    logic [sri_pkg::DEG_W-1:0]       target_3;
    logic [sri_pkg::DUR_W-1:0]       duration_ms;

    modport source (output valid, command, target_0, target_1, target_2, target_3,
                    duration_ms, input ready);
    modport sink   (input valid, command, target_0, target_1, target_2, target_3,
                    duration_ms, output ready);
endinterface

interface sri_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sri_pkg::PULSE_W-1:0]     pulse_0;
    logic [sri_pkg::PULSE_W-1:0]     pulse_1;
    logic [sri_pkg::PULSE_W-1:0]     pulse_2;
    logic [sri_pkg::PULSE_W-1:0]     pulse_3;
    logic                            moving;
    logic [sri_pkg::DEG_W-1:0]       angle_0;
    logic [sri_pkg::DEG_W-1:0]       angle_1;
    logic [sri_pkg::DEG_W-1:0]       angle_2;
    logic [sri_pkg::DEG_W-1:0]       angle_3;

    modport source (output valid, pulse_0, pulse_1, pulse_2, pulse_3, moving,
                    angle_0, angle_1, angle_2, angle_3, input ready);
    modport sink   (input valid, pulse_0, pulse_1, pulse_2, pulse_3, moving,
                    angle_0, angle_1, angle_2, angle_3, output ready);
endinterface

interface sri_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sri_pkg::CFG_IDX_W-1:0]   index;
    logic [sri_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/sri_divider.sv
// ----------------------------------------------------------------------------
// sri_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sri_divider #(
    parameter int DIVIDEND_W = sri_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = sri_pkg::DIVISOR_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  div_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  trial;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVISOR_W+1])
            begin
                rem_reg <= trial[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/sri_lane.sv
// ----------------------------------------------------------------------------
// sri_lane
// One servo: ramp state, step division and the pulse width pipeline.
// ----------------------------------------------------------------------------
module sri_lane (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sri_pkg::sri_lane_ctrl_t               ctrl,
    input  logic [sri_pkg::DEG_W-1:0]             target,
    input  logic [sri_pkg::DUR_W-1:0]             duration_ms,
    input  logic signed [sri_pkg::TRIM_W-1:0]     trim,
    input  logic                                  reverse,
    input  logic [sri_pkg::PULSE_W-1:0]           min_pulse_us,
    input  logic signed [sri_pkg::SPAN_W-1:0]     span,
    output logic                                  div_done,
    output logic [sri_pkg::DEG_W-1:0]             angle,
    output logic [sri_pkg::PULSE_W-1:0]           pulse
);
    import sri_pkg::*;

    logic [ANGLE_W-1:0]        angle_reg;
    logic [ANGLE_W-1:0]        angle_next;
    logic signed [STEP_W-1:0]  step_reg;
    logic signed [STEP_W-1:0]  step_next;
    logic [DEG_W-1:0]          goal_reg;
    logic                      neg_reg;

    logic [ANGLE_W-1:0]        a_reg;
    logic [ANGLE_W-1:0]        a_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic [BASE_W-1:0]         q1_reg;
    logic [BASE_W-1:0]         q1_next;
    logic [PULSE_W-1:0]        pulse_reg;

    logic [DEG_W-1:0]          goal_sat;
    logic signed [ANGLE_W+1:0] diff;
    logic [ANGLE_W:0]          diff_mag;
    logic [DIVIDEND_W-1:0]     dividend;
    logic [DIVIDEND_W-1:0]     quotient;
    logic                      quo_done;
    logic signed [CLAMP_W-1:0] ramp_sum;
    logic signed [CLAMP_W-1:0] trimmed;
    logic [BASE_W-1:0]         base;
    logic signed [SUM_W-1:0]   sum_wide;
    logic [SCALE_W-1:0]        scaled;

    // step = trunc((goal - angle) * 10 / duration)
    always_comb
    begin
        goal_sat = (target > DEG_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : target;
        diff     = $signed({2'b00, goal_sat, 8'h00}) - $signed({2'b00, angle_reg});
        diff_mag = diff[ANGLE_W+1] ? (ANGLE_W+1)'(-diff) : diff[ANGLE_W:0];
        dividend = DIVIDEND_W'({diff_mag, 3'b000}) + DIVIDEND_W'({diff_mag, 1'b0});
    end

    sri_divider #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.move_en && !ctrl.snap),
        .dividend (dividend),
        .divisor  (duration_ms),
        .done     (quo_done),
        .quotient (quotient)
    );

    always_comb
    begin
        ramp_sum = $signed({3'b000, angle_reg}) + $signed({step_reg[STEP_W-1], step_reg});
        angle_next = angle_reg;
        if (ctrl.move_en && ctrl.snap)
        begin
            angle_next = {goal_sat, 8'h00};
        end
        else if (ctrl.tick_en)
        begin
            angle_next = ctrl.last_tick ? {goal_reg, 8'h00} : clamp_q(ramp_sum);
        end

        step_next = step_reg;
        if (ctrl.move_en && ctrl.snap)
        begin
            step_next = '0;
        end
        else if (quo_done)
        begin
            step_next = neg_reg ? -$signed({1'b0, quotient[QUOT_W-1:0]})
                                :  $signed({1'b0, quotient[QUOT_W-1:0]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= ANGLE_W'(RESET_DEG * 256);
            step_reg  <= '0;
            goal_reg  <= DEG_W'(RESET_DEG);
            neg_reg   <= 1'b0;
        end
        else
        begin
            angle_reg <= angle_next;
            step_reg  <= step_next;
            if (ctrl.move_en)
            begin
                goal_reg <= goal_sat;
                neg_reg  <= diff[ANGLE_W+1];
            end
        end
    end

    // pulse pipeline: trim and mirror, span product, offset, divide by 46080
    always_comb
    begin
        trimmed = $signed({3'b000, angle_reg}) + $signed({{3{trim[TRIM_W-1]}}, trim, 8'h00});
        a_next  = clamp_q(trimmed);
        if (reverse)
        begin
            a_next = ANGLE_W'(FULL_Q) - a_next;
        end
        prod_next = $signed({1'b0, a_reg}) * span;
        base      = BASE_W'(min_pulse_us * BASE_W'(SCALE_MUL));
        sum_wide  = $signed({{(SUM_W-BASE_W){1'b0}}, base}) + SUM_W'(prod_reg >>> DIV_SHIFT);
        q1_next   = sum_wide[BASE_W-1:0];
        scaled    = SCALE_W'(q1_reg) * SCALE_W'(RECIP_45);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.trim_en)
        begin
            a_reg <= a_next;
        end
        if (ctrl.span_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.sum_en)
        begin
            q1_reg <= q1_next;
        end
        if (ctrl.scale_en)
        begin
            pulse_reg <= scaled[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
        end
    end

    assign div_done = quo_done;
    assign angle    = angle_reg[ANGLE_W-1:8];
    assign pulse    = pulse_reg;

endmodule

FILE: rtl/servo_ramp_interpolator_unit.sv
// ----------------------------------------------------------------------------
// servo_ramp_interpolator_unit
// Linear ramp of up to four servo angles with trimmed, mirrored pulse output.
// ----------------------------------------------------------------------------
// usage
//   req : one transaction per command; a move carries targets and a duration,
//         a tick advances a running ramp by one 10 ms step
//   rsp : one transaction per request with four pulse widths, the integer
//         angles and the moving flag
//   cfg : register writes (index 0..6), always ready; write only while the
//         unit is idle, indexes above 6 are dropped
//   latency: tick, short move: 5 cycles from req to rsp valid
//            ramped move: 25 cycles, set by the 19-cycle step divider that
//            each servo lane runs in parallel
//   throughput: one request per latency + 1 cycles; req is taken only in idle
//   stall: a finished result waits in the output register; the unit takes
//          the next request meanwhile and holds its own result back in the
//          deliver step until the register is free
//   reset: angles and goals at 80 degrees, no ramp, pulses 544..2400 us,
//          no mirroring, zero trims; the output register is empty
// ----------------------------------------------------------------------------
module servo_ramp_interpolator_unit #(
    parameter int SERVO_COUNT = sri_pkg::SERVO_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sri_req_if.sink   req,
    sri_rsp_if.source rsp,
    sri_cfg_if.sink   cfg
);
    import sri_pkg::*;

    // lanes actually built; servos above this report zero
    localparam int LANES = (SERVO_COUNT < FIELD_SERVOS) ? SERVO_COUNT : FIELD_SERVOS;

    // configuration registers
    logic [PULSE_W-1:0]       min_pulse_reg;
    logic [PULSE_W-1:0]       max_pulse_reg;
    logic [FIELD_SERVOS-1:0]  reverse_reg;
    logic signed [TRIM_W-1:0] trim_reg [FIELD_SERVOS];

    // control
    sri_state_t               state_reg;
    sri_state_t               state_next;
    logic [TICKS_W-1:0]       ticks_reg;
    logic [TICKS_W-1:0]       ticks_next;
    sri_lane_ctrl_t           lane_ctrl;
    logic                     req_accept;
    logic                     is_move;
    logic                     short_move;
    logic [DUR_W:0]           dur_round;
    logic [TICK_PROD_W-1:0]   tick_prod;
    logic signed [SPAN_W-1:0] span;

    // output register
    logic                     out_valid_reg;
    logic                     out_load;
    logic                     moving_out_reg;
    logic [PULSE_W-1:0]       pulse_out_reg [FIELD_SERVOS];
    logic [DEG_W-1:0]         angle_out_reg [FIELD_SERVOS];

    // lane results
    logic [DEG_W-1:0]         target      [FIELD_SERVOS];
    logic [PULSE_W-1:0]       lane_pulse  [FIELD_SERVOS];
    logic [DEG_W-1:0]         lane_angle  [FIELD_SERVOS];
    logic                     lane_done   [FIELD_SERVOS];

    assign target[0] = req.target_0;
    assign target[1] = req.target_1;
    assign target[2] = req.target_2;
    assign target[3] = req.target_3;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            reverse_reg   <= '0;
            for (int i = 0; i < FIELD_SERVOS; i++)
            begin
                trim_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MIN_PULSE: min_pulse_reg <= cfg.data;
                REG_MAX_PULSE: max_pulse_reg <= cfg.data;
                REG_REVERSE:   reverse_reg   <= cfg.data[FIELD_SERVOS-1:0];
                REG_TRIM_0:    trim_reg[0]   <= cfg.data[TRIM_W-1:0];
                REG_TRIM_1:    trim_reg[1]   <= cfg.data[TRIM_W-1:0];
                REG_TRIM_2:    trim_reg[2]   <= cfg.data[TRIM_W-1:0];
                REG_TRIM_3:    trim_reg[3]   <= cfg.data[TRIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // pulse span may be negative when max is below min
    assign span = $signed({1'b0, max_pulse_reg}) - $signed({1'b0, min_pulse_reg});

    // ramp length ceil(duration / 10) by reciprocal multiply
    always_comb
    begin
        dur_round = {1'b0, req.duration_ms} + (DUR_W+1)'(TICK_MS - 1);
        tick_prod = TICK_PROD_W'(dur_round) * TICK_PROD_W'(TICK_RECIP);
    end

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;
    assign is_move    = (req.command == CMD_MOVE);
    assign short_move = (req.duration_ms <= DUR_W'(TICK_MS));

    // sequencer: next state, tick count and lane controls
    always_comb
    begin
        state_next = state_reg;
        ticks_next = ticks_reg;
        lane_ctrl  = '0;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (is_move)
                    begin
                        lane_ctrl.move_en = 1'b1;
                        lane_ctrl.snap    = short_move;
                        if (short_move)
                        begin
                            ticks_next = '0;
                            state_next = ST_TRIM;
                        end
                        else
                        begin
                            ticks_next = tick_prod[TICK_RECIP_SHIFT+TICKS_W-1:TICK_RECIP_SHIFT];
                            state_next = ST_DIVIDE;
                        end
                    end
                    else
                    begin
                        if (ticks_reg != '0)
                        begin
                            ticks_next          = ticks_reg - TICKS_W'(1);
                            lane_ctrl.tick_en   = 1'b1;
                            lane_ctrl.last_tick = (ticks_reg == TICKS_W'(1));
                        end
                        state_next = ST_TRIM;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (lane_done[0])
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                lane_ctrl.trim_en = 1'b1;
                state_next        = ST_SPAN;
            end
            ST_SPAN:
            begin
                lane_ctrl.span_en = 1'b1;
                state_next        = ST_SUM;
            end
            ST_SUM:
            begin
                lane_ctrl.sum_en = 1'b1;
                state_next       = ST_SCALE;
            end
            ST_SCALE:
            begin
                lane_ctrl.scale_en = 1'b1;
                state_next         = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ticks_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ticks_reg <= ticks_next;
        end
    end

    // servo lanes; unbuilt servos read as zero
    for (genvar g = 0; g < FIELD_SERVOS; g++)
    begin : g_lane
        if (g < LANES)
        begin : g_on
            sri_lane u_lane (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (lane_ctrl),
                .target       (target[g]),
                .duration_ms  (req.duration_ms),
                .trim         (trim_reg[g]),
                .reverse      (reverse_reg[g]),
                .min_pulse_us (min_pulse_reg),
                .span         (span),
                .div_done     (lane_done[g]),
                .angle        (lane_angle[g]),
                .pulse        (lane_pulse[g])
            );
        end
        else
        begin : g_off
            assign lane_done[g]  = 1'b0;
            assign lane_angle[g] = '0;
            assign lane_pulse[g] = '0;
        end
    end

    // merge lane results into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            moving_out_reg <= (ticks_reg != '0);
            for (int i = 0; i < FIELD_SERVOS; i++)
            begin
                pulse_out_reg[i] <= lane_pulse[i];
                angle_out_reg[i] <= lane_angle[i];
            end
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.moving  = moving_out_reg;
    assign rsp.pulse_0 = pulse_out_reg[0];
    assign rsp.pulse_1 = pulse_out_reg[1];
    assign rsp.pulse_2 = pulse_out_reg[2];
    assign rsp.pulse_3 = pulse_out_reg[3];
    assign rsp.angle_0 = angle_out_reg[0];
    assign rsp.angle_1 = angle_out_reg[1];
    assign rsp.angle_2 = angle_out_reg[2];
    assign rsp.angle_3 = angle_out_reg[3];

endmodule

FILE: tb/sv/servo_ramp_interpolator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_ramp_interpolator_unit_test
// Self-checking bench for the servo ramp interpolator. It drives move and tick
// transactions, writes the pulse, mirror and trim registers between phases,
// and keeps a shadow of the four servo lanes to predict every result.
// Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module servo_ramp_interpolator_unit_test;

    import sri_pkg::*;

    localparam int     SERVOS        = SERVO_COUNT_DEF;
    localparam int     CLK_PERIOD    = 12;
    localparam int     RESET_CYCLES  = 9;
    // slightly longer than a ramped move takes through the unit
    localparam int     SETTLE_CYCLES = 30;
    localparam int     PHASE_ITEMS   = 605;
    localparam int     SETTING_SPAN  = 150;
    localparam longint RUN_LIMIT_NS  = 64'd10_000_000;

    // index past the last register, the unit must drop it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef logic [FIELD_SERVOS-1:0][DEG_W-1:0] deg_set_t;

    typedef struct packed {
        logic [FIELD_SERVOS-1:0][PULSE_W-1:0] pulse;
        logic                                 moving;
        logic [FIELD_SERVOS-1:0][DEG_W-1:0]   angle;
    } servo_frame_t;

    logic clk;
    logic rst_n;

    sri_req_if req ();
    sri_rsp_if rsp ();
    sri_cfg_if cfg ();

    servo_ramp_interpolator_unit #(
        .SERVO_COUNT(SERVOS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp),
        .cfg  (cfg)
    );

    // shadow registers
    int unsigned min_pulse;
    int unsigned max_pulse;
    logic [3:0]  mirror_mask;
    int          trim_deg [FIELD_SERVOS];

    // shadow ramp state, angles in Q8.8
    int          angle_q  [FIELD_SERVOS];
    int          step_q   [FIELD_SERVOS];
    int          goal_deg [FIELD_SERVOS];
    int unsigned ticks_left;

    servo_frame_t frames_due [$];

    int items_sent;
    int error_count;
    int send_idle_pct;
    int take_idle_pct;

    // ------------------------------------------------------------------------
    // shadow model of the lanes
    // ------------------------------------------------------------------------

    function automatic int clamp_angle(input longint v);
        if (v < 0)
        begin
            return 0;
        end
        if (v > FULL_Q)
        begin
            return FULL_Q;
        end
        return int'(v);
    endfunction

    // trim, saturate, mirror, then scale linearly between the pulse limits
    function automatic logic [PULSE_W-1:0] pulse_width_for(input int i);
        longint a;
        longint num;
        a = clamp_angle(longint'(angle_q[i]) + longint'(trim_deg[i]) * 256);
        if (mirror_mask[i])
        begin
            a = FULL_Q - a;
        end
        num = longint'(min_pulse) * FULL_Q
              + a * (longint'(max_pulse) - longint'(min_pulse));
        if (num < 0)
        begin
            num = 0;
        end
        return PULSE_W'(num / FULL_Q);
    endfunction

    // updates the shadow state for one transaction and returns its result
    function automatic servo_frame_t next_servo_frame(input logic command,
                                                      input deg_set_t target,
                                                      input logic [DUR_W-1:0] dur);
        servo_frame_t f;
        longint       diff;
        f = '0;
        if (command == CMD_MOVE)
        begin
            for (int i = 0; i < SERVOS; i++)
            begin
                goal_deg[i] = (target[i] > MAX_DEG) ? MAX_DEG : int'(target[i]);
            end
            if (dur <= TICK_MS)
            begin
                for (int i = 0; i < SERVOS; i++)
                begin
                    angle_q[i] = goal_deg[i] * 256;
                    step_q[i]  = 0;
                end
                ticks_left = 0;
            end
            else
            begin
                // division truncates toward zero, as the unit's step divider
                for (int i = 0; i < SERVOS; i++)
                begin
                    diff      = longint'(goal_deg[i]) * 256 - angle_q[i];
                    step_q[i] = int'((diff * TICK_MS) / longint'(dur));
                end
                ticks_left = (int'(dur) + TICK_MS - 1) / TICK_MS;
            end
        end
        else if (ticks_left != 0)
        begin
            ticks_left--;
            for (int i = 0; i < SERVOS; i++)
            begin
                if (ticks_left == 0)
                begin
                    angle_q[i] = goal_deg[i] * 256;
                end
                else
                begin
                    angle_q[i] = clamp_angle(longint'(angle_q[i]) + step_q[i]);
                end
            end
        end
        for (int i = 0; i < FIELD_SERVOS; i++)
        begin
            if (i < SERVOS)
            begin
                f.pulse[i] = pulse_width_for(i);
                f.angle[i] = DEG_W'(angle_q[i] >> 8);
            end
        end
        f.moving = (ticks_left != 0);
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------------

    task automatic send_item(input logic command, input deg_set_t target,
                             input logic [DUR_W-1:0] dur);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid       = 1'b1;
        req.command     = command;
        req.target_0    = target[0];
        req.target_1    = target[1];
        req.target_2    = target[2];
        req.target_3    = target[3];
        req.duration_ms = dur;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        frames_due.push_back(next_servo_frame(command, target, dur));
        items_sent++;
        @(negedge clk);
    endtask

    // targets and duration of a tick are don't-care, so they get noise
    task automatic send_tick();
        deg_set_t junk;
        for (int i = 0; i < FIELD_SERVOS; i++)
        begin
            junk[i] = DEG_W'($urandom_range(255));
        end
        send_item(CMD_TICK, junk, DUR_W'($urandom_range(65535)));
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic settle_unit();
        req.valid = 1'b0;
        while (frames_due.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DAT_W-1:0] data);
        cfg.valid = 1'b1;
        cfg.index = index;
        cfg.data  = data;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        case (index)
            REG_MIN_PULSE: min_pulse   = data;
            REG_MAX_PULSE: max_pulse   = data;
            REG_REVERSE:   mirror_mask = data[3:0];
            REG_TRIM_0,
            REG_TRIM_1,
            REG_TRIM_2,
            REG_TRIM_3:    trim_deg[index - REG_TRIM_0] = int'($signed(data[TRIM_W-1:0]));
            default:       ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // negative trims go out sign extended to 12 bits, so the upper data bits
    // of the trim registers are exercised too
    task automatic apply_settings(input int lo_us, input int hi_us, input logic [3:0] mask,
                                  input int trims [FIELD_SERVOS]);
        settle_unit();
        write_reg(REG_MIN_PULSE, CFG_DAT_W'(lo_us));
        write_reg(REG_MAX_PULSE, CFG_DAT_W'(hi_us));
        write_reg(REG_REVERSE, CFG_DAT_W'(mask));
        for (int i = 0; i < FIELD_SERVOS; i++)
        begin
            write_reg(CFG_IDX_W'(REG_TRIM_0 + i), CFG_DAT_W'(trims[i]));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // a tick with no ramp running returns the reset pulses at 80 degrees
    task automatic test_reset_state();
        send_tick();
        send_tick();
    endtask

    task automatic test_ramp_directed();
        // snaps: zero duration, targets over 180 saturate, then the 10 ms boundary
        send_item(CMD_MOVE, {8'd90, 8'd255, 8'd180, 8'd0}, 16'd0);
        send_item(CMD_MOVE, {8'd0, 8'd180, 8'd0, 8'd180}, 16'd10);
        // shortest ramp: two ticks, the last one snaps, then an idle tick
        send_item(CMD_MOVE, {8'd123, 8'd37, 8'd180, 8'd0}, 16'd11);
        repeat (3) send_tick();
        // ramp interrupted halfway by a new move from the current angles
        send_item(CMD_MOVE, {8'd180, 8'd0, 8'd0, 8'd180}, 16'd35);
        repeat (2) send_tick();
        send_item(CMD_MOVE, {8'd90, 8'd90, 8'd90, 8'd90}, 16'd20);
        repeat (3) send_tick();
        // longest ramp, tiny steps, dropped by a snap
        send_item(CMD_MOVE, {8'd255, 8'd255, 8'd255, 8'd255}, 16'hFFFF);
        repeat (2) send_tick();
        send_item(CMD_MOVE, {8'd0, 8'd0, 8'd0, 8'd0}, 16'd0);
    endtask

    task automatic test_register_extremes();
        // full span, all lanes mirrored, trims at and beyond their range
        apply_settings(0, 4095, 4'hF, '{90, -90, 127, -128});
        send_item(CMD_MOVE, {8'd45, 8'd90, 8'd180, 8'd0}, 16'd0);
        send_item(CMD_MOVE, {8'd180, 8'd0, 8'd0, 8'd180}, 16'd0);
        // inverted span
        apply_settings(4095, 0, 4'b0101, '{0, 0, 0, 0});
        send_item(CMD_MOVE, {8'd10, 8'd170, 8'd0, 8'd180}, 16'd0);
        send_item(CMD_MOVE, {8'd180, 8'd0, 8'd90, 8'd1}, 16'd0);
        // flat span, and a write to the spare index that must change nothing
        apply_settings(1500, 1500, 4'b1010, '{-1, 1, -45, 45});
        write_reg(REG_SPARE, 12'hFFF);
        send_item(CMD_MOVE, {8'd33, 8'd66, 8'd99, 8'd132}, 16'd0);
        send_item(CMD_MOVE, {8'd0, 8'd180, 8'd0, 8'd180}, 16'd0);
        // back to the reset values
        apply_settings(544, 2400, 4'h0, '{0, 0, 0, 0});
        send_item(CMD_MOVE, {8'd80, 8'd80, 8'd80, 8'd80}, 16'd0);
        send_tick();
    endtask

    // mostly complete ramps with random targets; the rest are ramps cut short
    // by the next move, snaps and stray ticks
    task automatic test_random_traffic(input int goal, input int send_pct, input int take_pct);
        int               stop_at;
        int               block_end;
        int               lo_us;
        int               hi_us;
        int               kind;
        int               trims [FIELD_SERVOS];
        logic [DUR_W-1:0] dur;
        deg_set_t         target;
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        stop_at       = items_sent + goal;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(3) != 0)
            begin
                lo_us = $urandom_range(400, 1000);
                hi_us = $urandom_range(1800, 2600);
            end
            else
            begin
                lo_us = $urandom_range(4095);
                hi_us = $urandom_range(4095);
            end
            for (int i = 0; i < FIELD_SERVOS; i++)
            begin
                if ($urandom_range(4) == 0)
                begin
                    trims[i] = int'($urandom_range(255)) - 128;
                end
                else
                begin
                    trims[i] = int'($urandom_range(180)) - 90;
                end
            end
            apply_settings(lo_us, hi_us, 4'($urandom_range(15)), trims);

            block_end = items_sent + SETTING_SPAN;
            while (items_sent < block_end && items_sent < stop_at)
            begin
                for (int i = 0; i < FIELD_SERVOS; i++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        target[i] = DEG_W'($urandom_range(255));
                    end
                    else
                    begin
                        target[i] = DEG_W'($urandom_range(MAX_DEG));
                    end
                end
                kind = $urandom_range(99);
                if (kind < 70)
                begin
                    // whole ramp, sometimes followed by idle ticks
                    dur = DUR_W'($urandom_range(11, 250));
                    send_item(CMD_MOVE, target, dur);
                    repeat ((int'(dur) + TICK_MS - 1) / TICK_MS + $urandom_range(2))
                    begin
                        send_tick();
                    end
                end
                else if (kind < 85)
                begin
                    // any duration, mostly left unfinished
                    dur = DUR_W'($urandom_range(11, 65535));
                    send_item(CMD_MOVE, target, dur);
                    repeat ($urandom_range(5))
                    begin
                        send_tick();
                    end
                end
                else if (kind < 95)
                begin
                    send_item(CMD_MOVE, target, DUR_W'($urandom_range(TICK_MS)));
                end
                else
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send_tick();
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result checker: compares each result transaction with the oldest
    // prediction, and stalls the result channel at random
    // ------------------------------------------------------------------------

    task automatic check_frame();
        servo_frame_t got;
        servo_frame_t want;
        got.pulse[0] = rsp.pulse_0;
        got.pulse[1] = rsp.pulse_1;
        got.pulse[2] = rsp.pulse_2;
        got.pulse[3] = rsp.pulse_3;
        got.moving   = rsp.moving;
        got.angle[0] = rsp.angle_0;
        got.angle[1] = rsp.angle_1;
        got.angle[2] = rsp.angle_2;
        got.angle[3] = rsp.angle_3;
        if (frames_due.size() == 0)
        begin
            $error("result transaction with nothing expected: moving %0b", got.moving);
            error_count++;
            return;
        end
        want = frames_due.pop_front();
        for (int i = 0; i < FIELD_SERVOS; i++)
        begin
            if (got.pulse[i] !== want.pulse[i])
            begin
                $error("pulse_%0d: expected %0d, actual %0d", i, want.pulse[i], got.pulse[i]);
                error_count++;
            end
            if (got.angle[i] !== want.angle[i])
            begin
                $error("angle_%0d: expected %0d, actual %0d", i, want.angle[i], got.angle[i]);
                error_count++;
            end
        end
        if (got.moving !== want.moving)
        begin
            $error("moving: expected %0b, actual %0b", want.moving, got.moving);
            error_count++;
        end
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                check_frame();
            end
            @(negedge clk);
            rsp.ready = ($urandom_range(99) >= take_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // clock, watchdog and test sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // generous bound: the full run needs well under a tenth of this
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.command     = CMD_TICK;
        req.target_0    = '0;
        req.target_1    = '0;
        req.target_2    = '0;
        req.target_3    = '0;
        req.duration_ms = '0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        send_idle_pct   = 0;
        take_idle_pct   = 0;
        items_sent      = 0;
        error_count     = 0;

        // shadow state as it comes out of reset
        min_pulse   = MIN_PULSE_RST;
        max_pulse   = MAX_PULSE_RST;
        mirror_mask = '0;
        ticks_left  = 0;
        for (int i = 0; i < FIELD_SERVOS; i++)
        begin
            trim_deg[i] = 0;
            angle_q[i]  = RESET_DEG * 256;
            step_q[i]   = 0;
            goal_deg[i] = RESET_DEG;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_ramp_directed();
        test_register_extremes();
        // sender idling lightly and receiver heavily, then the reverse, then flat out
        test_random_traffic(PHASE_ITEMS, 27, 48);
        test_random_traffic(PHASE_ITEMS, 48, 27);
        test_random_traffic(PHASE_ITEMS, 0, 0);

        settle_unit();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
